// ----- hw/rtl/u8u2_pkg.sv -----
// shared types, constants and lead decode helper for the utf-8 to ucs-2 decoder
package u8u2_pkg;

    localparam logic [15:0] CODE_REPLACE  = 16'hFFFD;
    localparam logic [15:0] CODE_TRUNC    = 16'h0000;
    localparam int          PARTIAL_WIDTH = 10;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        run_end;
    } t_result;

    // unit for a lead byte that also ends the message
    function automatic logic [15:0] lead_final_unit(input logic [7:0] b);
        logic [15:0] unit;
        if (!b[7]) begin
            unit = {8'h00, b};
        end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110) begin
            unit = CODE_TRUNC;
        end else begin
            unit = CODE_REPLACE;
        end
        return unit;
    endfunction

endpackage

// ----- hw/rtl/utf8_to_ucs2_decoder.sv -----
// utf-8 to ucs-2 decoder top level: lead/continuation tracking and result queue
//
// Takes one utf-8 byte per cycle, when ready, on the slave stream (tlast marks the
// final byte of a message) and emits 16-bit ucs-2 code units on the master stream,
// tlast set on the last unit a byte causes. Two- and three-byte sequences are
// assembled in a small phase register; continuation bytes are masked, not checked;
// other leads give 0xFFFD and sequences cut off by the message end give 0. Each
// byte is decoded in the cycle it is accepted and its units go into a four-entry
// result queue, so the block sustains one byte per cycle while the output keeps
// up, with the first unit valid in the cycle after acceptance. A three-byte lead
// followed by a final byte produces two units, which leave one per cycle as the
// output takes them; the input is ready whenever the queue has two free entries.
module utf8_to_ucs2_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // final_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] code_unit
    output logic        m_axis_tlast    // run_end
);

    localparam int DEPTH   = 4;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int PW      = u8u2_pkg::PARTIAL_WIDTH;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TWO_TAIL,
        PH_THREE_MID,
        PH_THREE_TAIL
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [PW-1:0]      r_partial, n_partial;
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    u8u2_pkg::t_result  r_mem [DEPTH];

    logic               accept;
    logic               pop;
    logic [1:0]         push;
    u8u2_pkg::t_result  res0, res1;
    logic [7:0]         b;
    logic               fin;

    assign b      = s_axis_tdata;
    assign fin    = s_axis_tlast;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign pop    = m_axis_tvalid && m_axis_tready;

    assign s_axis_tready = (r_count <= CNT_W'(DEPTH - 2));
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = r_mem[r_rd_ptr].code_unit;
    assign m_axis_tlast  = r_mem[r_rd_ptr].run_end;

    always_comb begin
        n_phase   = r_phase;
        n_partial = r_partial;
        push      = 2'd0;
        res0      = '{code_unit: u8u2_pkg::CODE_TRUNC, run_end: 1'b1};
        res1      = '{code_unit: u8u2_pkg::lead_final_unit(b), run_end: 1'b1};
        case (r_phase)
            PH_TWO_TAIL, PH_THREE_TAIL: begin
                res0.code_unit = {r_partial, b[5:0]};
                push           = 2'd1;
                n_phase        = PH_IDLE;
                n_partial      = '0;
            end
            PH_THREE_MID: begin
                if (!fin) begin
                    n_partial = {r_partial[3:0], b[5:0]};
                    n_phase   = PH_THREE_TAIL;
                end else begin
                    // sequence cut short: a zero unit, then the byte as a final lead
                    res0.run_end = 1'b0;
                    push         = 2'd2;
                    n_phase      = PH_IDLE;
                    n_partial    = '0;
                end
            end
            default: begin
                if (!b[7]) begin
                    res0.code_unit = {8'h00, b};
                    push           = 2'd1;
                end else if (b[7:5] == 3'b110) begin
                    if (fin) begin
                        push = 2'd1;
                    end else begin
                        n_partial = {5'b0, b[4:0]};
                        n_phase   = PH_TWO_TAIL;
                    end
                end else if (b[7:4] == 4'b1110) begin
                    if (fin) begin
                        push = 2'd1;
                    end else begin
                        n_partial = {6'b0, b[3:0]};
                        n_phase   = PH_THREE_MID;
                    end
                end else begin
                    res0.code_unit = u8u2_pkg::CODE_REPLACE;
                    push           = 2'd1;
                end
            end
        endcase
        if (!accept) begin
            n_phase   = r_phase;
            n_partial = r_partial;
            push      = 2'd0;
        end
        n_count = r_count + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_partial <= '0;
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_count   <= '0;
        end else begin
            r_phase   <= n_phase;
            r_partial <= n_partial;
            r_wr_ptr  <= r_wr_ptr + PTR_W'(push);
            r_rd_ptr  <= r_rd_ptr + PTR_W'(pop);
            r_count   <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push != 2'd0) begin
            r_mem[r_wr_ptr] <= res0;
        end
        if (push == 2'd2) begin
            r_mem[r_wr_ptr + PTR_W'(1)] <= res1;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    a_msg_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && s_axis_tlast |=> r_phase == PH_IDLE)
        else $error("phase not idle after final byte");

    a_two_tail_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_TWO_TAIL |-> r_partial[PW-1:5] == '0)
        else $error("two-byte partial has stray high bits");

    a_mid_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_THREE_MID |-> r_partial[PW-1:4] == '0)
        else $error("three-byte lead partial has stray high bits");

    a_pair_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push == 2'd2 |-> accept && s_axis_tlast && r_phase == PH_THREE_MID)
        else $error("two units pushed outside a cut-short sequence");

endmodule

// ----- test/utf8_to_ucs2_decoder_test.sv -----
// self-checking stream testbench for the utf-8 to ucs-2 decoder
module utf8_to_ucs2_decoder_test;

    typedef enum logic [1:0] {
        WAIT_LEAD,
        WAIT_TWO_TAIL,
        WAIT_THREE_MID,
        WAIT_THREE_TAIL
    } t_seq_phase;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } t_text_item;

    localparam int RANDOM_BYTES = 1850;
    localparam int STALL_AT     = 500;
    localparam int STALL_CYCLES = 300;
    localparam int QUIET_FROM   = 1000;
    localparam int QUIET_TO     = 1400;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] text_byte
    logic        s_axis_tlast;   // final_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [15:0] code_unit
    logic        m_axis_tlast;   // run_end

    t_text_item          text_pending[$];
    u8u2_pkg::t_result   units_expected[$];

    t_seq_phase  seq_phase;
    logic [9:0]  partial_bits;

    logic        byte_taken;
    int          bytes_taken;
    int          error_count;
    int          hold_left;
    logic        stall_done;

    utf8_to_ucs2_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    task automatic expect_unit(input logic [15:0] unit, input logic last);
        u8u2_pkg::t_result r;
        r.code_unit = unit;
        r.run_end   = last;
        units_expected = {units_expected, r};
    endtask

    // lead byte handling, also used for the byte that cuts a three-byte sequence short
    task automatic decode_lead(input logic [7:0] b, input logic fin);
        if (!b[7]) begin
            expect_unit({8'h00, b}, 1'b1);
        end else if (b[7:5] == 3'b110) begin
            if (fin) begin
                expect_unit(u8u2_pkg::CODE_TRUNC, 1'b1);
            end else begin
                partial_bits = {5'b0, b[4:0]};
                seq_phase    = WAIT_TWO_TAIL;
            end
        end else if (b[7:4] == 4'b1110) begin
            if (fin) begin
                expect_unit(u8u2_pkg::CODE_TRUNC, 1'b1);
            end else begin
                partial_bits = {6'b0, b[3:0]};
                seq_phase    = WAIT_THREE_MID;
            end
        end else begin
            expect_unit(u8u2_pkg::CODE_REPLACE, 1'b1);
        end
    endtask

    task automatic decode_utf8_byte(input logic [7:0] b, input logic fin);
        case (seq_phase)
            WAIT_TWO_TAIL, WAIT_THREE_TAIL: begin
                expect_unit({partial_bits, b[5:0]}, 1'b1);
                seq_phase    = WAIT_LEAD;
                partial_bits = '0;
            end
            WAIT_THREE_MID: begin
                if (!fin) begin
                    partial_bits = {partial_bits[3:0], b[5:0]};
                    seq_phase    = WAIT_THREE_TAIL;
                end else begin
                    expect_unit(u8u2_pkg::CODE_TRUNC, 1'b0);
                    seq_phase    = WAIT_LEAD;
                    partial_bits = '0;
                    decode_lead(b, 1'b1);
                end
            end
            default: begin
                decode_lead(b, fin);
            end
        endcase
    endtask

    task automatic add_byte(input logic [7:0] b, input logic fin);
        t_text_item it;
        it.text_byte  = b;
        it.final_byte = fin;
        text_pending = {text_pending, it};
    endtask

    function automatic logic [7:0] cont_byte();
        if ($urandom_range(9) == 0) begin
            return 8'($urandom_range(255));
        end
        return {2'b10, 6'($urandom_range(63))};
    endfunction

    // one message of mostly well-formed sequences, now and then cut short or noisy
    task automatic add_message(inout int count);
        logic [7:0] msg[$];
        int         units;
        int         kind;
        int         cut;
        units = $urandom_range(1, 8);
        for (int u = 0; u < units; u++) begin
            kind = $urandom_range(9);
            if (kind < 4) begin
                msg = {msg, {1'b0, 7'($urandom_range(127))}};
            end else if (kind < 6) begin
                msg = {msg, {3'b110, 5'($urandom_range(31))}};
                msg = {msg, cont_byte()};
            end else if (kind < 8) begin
                msg = {msg, {4'b1110, 4'($urandom_range(15))}};
                msg = {msg, cont_byte()};
                msg = {msg, cont_byte()};
            end else begin
                msg = {msg, 8'($urandom_range(255))};
            end
        end
        if ($urandom_range(9) == 0 && msg.size() > 1) begin
            cut = $urandom_range(1, 2);
            if (cut >= msg.size()) begin
                cut = msg.size() - 1;
            end
            repeat (cut) void'(msg.pop_back());
        end
        for (int i = 0; i < msg.size(); i++) begin
            add_byte(msg[i], i == msg.size() - 1);
        end
        count += msg.size();
    endtask

    // predictor and checker
    always @(posedge i_clk) begin
        u8u2_pkg::t_result want;
        if (!i_rst_n) begin
            byte_taken   <= 1'b0;
            bytes_taken  <= 0;
            seq_phase    = WAIT_LEAD;
            partial_bits = '0;
        end else begin
            byte_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                decode_utf8_byte(s_axis_tdata, s_axis_tlast);
                bytes_taken <= bytes_taken + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (units_expected.size() == 0) begin
                    $error("unexpected code unit %h", m_axis_tdata);
                    error_count = error_count + 1;
                end else begin
                    want = units_expected.pop_front();
                    if (m_axis_tdata !== want.code_unit) begin
                        $error("code_unit expected %h got %h", want.code_unit, m_axis_tdata);
                        error_count = error_count + 1;
                    end
                    if (m_axis_tlast !== want.run_end) begin
                        $error("run_end expected %b got %b", want.run_end, m_axis_tlast);
                        error_count = error_count + 1;
                    end
                end
            end
        end
    end

    // byte sender
    always @(negedge i_clk) begin
        t_text_item it;
        logic       quiet;
        quiet = bytes_taken >= QUIET_FROM && bytes_taken < QUIET_TO;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || byte_taken) begin
            if (text_pending.size() != 0 && (quiet || $urandom_range(99) >= 20)) begin
                it = text_pending.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= it.text_byte;
                s_axis_tlast  <= it.final_byte;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // unit receiver, with one long hold-off to back the block up
    always @(negedge i_clk) begin
        logic quiet;
        quiet = bytes_taken >= QUIET_FROM && bytes_taken < QUIET_TO;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            stall_done    <= 1'b0;
        end else if (!stall_done && bytes_taken >= STALL_AT) begin
            m_axis_tready <= 1'b0;
            hold_left     <= STALL_CYCLES;
            stall_done    <= 1'b1;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else begin
            m_axis_tready <= quiet || $urandom_range(99) >= 20;
        end
    end

    initial begin
        int count;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        error_count   = 0;

        // extremes, well-formed sequences and overlong forms
        add_byte(8'h00, 1'b0);
        add_byte(8'h7F, 1'b1);
        add_byte(8'hC3, 1'b0);
        add_byte(8'hA9, 1'b1);
        add_byte(8'hC0, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'hE2, 1'b0);
        add_byte(8'h82, 1'b0);
        add_byte(8'hAC, 1'b1);
        add_byte(8'hE0, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h80, 1'b0);
        // stray continuations and four-byte or invalid leads
        add_byte(8'h80, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hF0, 1'b0);
        add_byte(8'hFF, 1'b1);
        // leads cut off by the message end
        add_byte(8'hC3, 1'b1);
        add_byte(8'hEF, 1'b1);
        // three-byte sequence cut short, the final byte decoded again as a lead
        add_byte(8'hE2, 1'b0);
        add_byte(8'h41, 1'b1);
        add_byte(8'hE2, 1'b0);
        add_byte(8'hC3, 1'b1);
        add_byte(8'hE2, 1'b0);
        add_byte(8'hF5, 1'b1);
        // non-continuation bytes taken as tails
        add_byte(8'hDF, 1'b0);
        add_byte(8'h41, 1'b1);
        add_byte(8'hEF, 1'b0);
        add_byte(8'hC5, 1'b0);
        add_byte(8'hFF, 1'b1);

        count = 0;
        while (count < RANDOM_BYTES) begin
            add_message(count);
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (text_pending.size() != 0 || s_axis_tvalid || units_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && units_expected.size() == 0) begin
            $display("utf8_to_ucs2_decoder_test OK");
        end else begin
            $display("utf8_to_ucs2_decoder_test NOT OK");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("utf8_to_ucs2_decoder_test NOT OK");
        $finish;
    end

endmodule
